[hdl/pidl_pkg.sv]
`default_nettype none
package pidl_pkg;

  // list geometry
  localparam int unsigned CAPACITY = 64;
  localparam int unsigned IDX_W    = $clog2(CAPACITY);
  localparam int unsigned CNT_W    = $clog2(CAPACITY + 1);
  localparam int unsigned DATA_W   = 32;
  localparam int unsigned POS_W    = 6;
  localparam int unsigned CNT_O_W  = 7;

  // operation codes
  localparam logic [1:0] MODE_INSERT = 2'd0;
  localparam logic [1:0] MODE_DELETE = 2'd1;
  localparam logic [1:0] MODE_READ   = 2'd2;

  // result status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_RANGE = 2'd2;

  // control broadcast to every cell of the chain
  typedef struct packed {
    logic              ins;    // shift up from position, load value there
    logic              del;    // shift down from position
    logic [IDX_W-1:0]  pos;    // target position (insert already clipped to count)
    logic [IDX_W-1:0]  rd_pos; // position whose entry is read out
    logic [DATA_W-1:0] value;  // value to insert
  } cell_ctrl_t;

endpackage
`default_nettype wire

[hdl/pidl_cell.sv]
`default_nettype none
module pidl_cell
  import pidl_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic [IDX_W-1:0]  cell_idx_i,
  input  wire cell_ctrl_t        ctrl_i,
  input  wire logic [DATA_W-1:0] prev_data_i,
  input  wire logic [DATA_W-1:0] next_data_i,
  output logic      [DATA_W-1:0] data_o,
  output logic      [DATA_W-1:0] rd_data_o
);

  logic [DATA_W-1:0] data_q;
  logic [DATA_W-1:0] data_d;

  // pick the new entry: neighbor below, neighbor above, new value or hold
  always_comb begin
    data_d = data_q;
    if (ctrl_i.ins) begin
      if (cell_idx_i > ctrl_i.pos) begin
        data_d = prev_data_i;
      end else if (cell_idx_i == ctrl_i.pos) begin
        data_d = ctrl_i.value;
      end
    end else if (ctrl_i.del) begin
      if (cell_idx_i >= ctrl_i.pos) begin
        data_d = next_data_i;
      end
    end
  end

  // entry storage, no reset needed
  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o    = data_q;
  // drive the read bus only when addressed
  assign rd_data_o = (cell_idx_i == ctrl_i.rd_pos) ? data_q : '0;

endmodule
`default_nettype wire

[hdl/positional_insert_delete_list.sv]
`default_nettype none
// Ordered list of up to 64 signed 32-bit entries held in a chain of cells.
// Insert (mode 0) places a value at a position and moves later entries up;
// a position at or past the count appends. Delete (mode 1) removes an entry
// and moves later entries down. Read (mode 2) returns the entry at a position.
// Every transaction yields one result with the count after the operation,
// an empty flag and a status (0 ok, 1 full and insert dropped, 2 position out
// of range or unused mode). All cells shift in parallel, and the result is
// registered in the cycle after the input is accepted. A new transaction may
// be accepted every cycle while no result waits untaken, including the cycle
// in which the previous result is taken.
module positional_insert_delete_list
  import pidl_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_ready_o,
  input  wire logic [1:0]           mode_i,
  input  wire logic [POS_W-1:0]     position_i,
  input  wire logic signed [DATA_W-1:0] value_i,
  output logic                      out_valid_o,
  input  wire logic                 out_ready_i,
  output logic signed [DATA_W-1:0]  read_value_o,
  output logic [CNT_O_W-1:0]        count_o,
  output logic                      is_empty_o,
  output logic [1:0]                status_o
);

  logic              accept;
  logic [CNT_W-1:0]  count_q, count_d;
  logic              out_valid_q;
  logic [DATA_W-1:0] rd_value_q, rd_value_d;
  logic [CNT_W-1:0]  res_count_q;
  logic [1:0]        status_q, status_d;
  logic [CNT_W-1:0]  pos_ext;
  logic              in_range;
  logic              full;
  cell_ctrl_t        ctrl;
  logic [DATA_W-1:0] cell_data [CAPACITY];
  logic [DATA_W-1:0] cell_rd   [CAPACITY];
  logic [DATA_W-1:0] rd_bus;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  assign pos_ext  = CNT_W'(position_i);
  assign in_range = pos_ext < count_q;
  assign full     = count_q == CNT_W'(CAPACITY);

  // decode the transaction into cell controls, next count and status
  always_comb begin
    ctrl        = '0;
    ctrl.value  = value_i;
    ctrl.rd_pos = IDX_W'(position_i);
    count_d     = count_q;
    status_d    = ST_OK;
    unique case (mode_i)
      MODE_INSERT: begin
        if (full) begin
          status_d = ST_FULL;
        end else begin
          ctrl.ins = accept;
          ctrl.pos = in_range ? IDX_W'(position_i) : IDX_W'(count_q);
          count_d  = count_q + CNT_W'(1);
        end
      end
      MODE_DELETE: begin
        if (!in_range) begin
          status_d = ST_RANGE;
        end else begin
          ctrl.del = accept;
          ctrl.pos = IDX_W'(position_i);
          count_d  = count_q - CNT_W'(1);
        end
      end
      MODE_READ: begin
        if (!in_range) begin
          status_d = ST_RANGE;
        end
      end
      default: begin
        status_d = ST_RANGE;
      end
    endcase
  end

  // chain of entry cells, each wired to its two neighbors
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    pidl_cell u_cell (
      .clk_i       (clk_i),
      .cell_idx_i  (IDX_W'(i)),
      .ctrl_i      (ctrl),
      .prev_data_i (cell_data[(i == 0) ? 0 : i - 1]),
      .next_data_i (cell_data[(i == CAPACITY - 1) ? i : i + 1]),
      .data_o      (cell_data[i]),
      .rd_data_o   (cell_rd[i])
    );
  end

  // combine the per-cell read outputs, only the addressed cell is nonzero
  always_comb begin
    rd_bus = '0;
    for (int j = 0; j < CAPACITY; j++) begin
      rd_bus = rd_bus | cell_rd[j];
    end
  end

  assign rd_value_d = (mode_i == MODE_READ && in_range) ? rd_bus : '0;

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        count_q <= count_d;
      end
      if (accept) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (accept) begin
      rd_value_q  <= rd_value_d;
      res_count_q <= count_d;
      status_q    <= status_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign read_value_o = rd_value_q;
  assign count_o      = CNT_O_W'(res_count_q);
  assign is_empty_o   = res_count_q == '0;
  assign status_o     = status_q;

endmodule
`default_nettype wire
